FILE: rtl/tws_pkg.sv
// package for the temperature window statistics block
// shared widths, constants and divider handshake types; no dependencies

package tws_pkg;

  // sizing
  localparam int WINDOW_DEPTH = 64;
  localparam int SAMPLES_LOG2 = 7;

  // fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int TEMP_W   = 8;
  localparam int SCALE_W  = 8;
  localparam int WLEN_W   = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // derived widths
  localparam int BLOCK_LEN = 1 << SAMPLES_LOG2;
  localparam int ACC_W     = SAMPLE_W + SAMPLES_LOG2;
  localparam int CNT_W     = SAMPLES_LOG2 + 1;
  localparam int WIN_IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int LEN_W     = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W     = $clog2(255 * WINDOW_DEPTH + 1);
  localparam int DIV_CNT_W = $clog2(SUM_W + 1);
  localparam int PROD_W    = SAMPLE_W + SCALE_W;

  // reset values
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(170);
  localparam logic [WLEN_W-1:0]  WLEN_RESET  = WLEN_W'(50);
  localparam logic [TEMP_W-1:0]  LOW_RESET   = TEMP_W'(255);

  // input commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = CFG_IDX_W'(1);

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [LEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  // clamp the window length register to 1..WINDOW_DEPTH
  function automatic logic [LEN_W-1:0] effective_len(input logic [WLEN_W-1:0] wl);
    logic [LEN_W-1:0] res;
    if (wl == '0) begin
      res = LEN_W'(1);
    end else if (9'(wl) > 9'(WINDOW_DEPTH)) begin
      res = LEN_W'(WINDOW_DEPTH);
    end else begin
      res = LEN_W'(wl);
    end
    return res;
  endfunction

endpackage

FILE: rtl/tws_div.sv
// restoring divider, one quotient bit per cycle, for the window mean
// depends on tws_pkg for widths and the request/response structs

module tws_div
  import tws_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0]     rem_q, rem_d;
  logic [SUM_W-1:0]     quo_q, quo_d;
  logic [LEN_W-1:0]     div_q, div_d;
  logic [LEN_W:0]       trial;
  logic                 fits;

  // one shift and subtract step
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(SUM_W);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? LEN_W'(trial - {1'b0, div_q}) : trial[LEN_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], fits};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: rtl/temperature_window_statistics.sv
// temperature window statistics top level: block averaging, window and extremes
// depends on tws_pkg and instantiates tws_div for the window mean
//
// input channel: in_valid_i / in_stall_o with command_i and sample_i. a sample
// transfer only adds into the block accumulator. the transfer that completes
// a block of 2^SAMPLES_LOG2 samples starts a sequence: multiply by the scale
// factor together with the window memory read, window update, then the serial
// divider (one quotient bit per cycle) for the mean, then the final step that
// offers the result; in_stall_o stays high until that final step is done.
// a clear command produces no result.
// output channel: out_valid_o / out_stall_i. the result sits in an output
// register, so sample transfers go on while a result waits; a new result
// waits in the final step until the output register is free.
// configuration: cfg_valid_i / cfg_ready_o, accepted only while no completed
// block is being processed; writing the window length empties the window.
// reset: statistics cleared, minimum at 255, scale 170, window length 50; the
// window memory has no reset; its read data is only used for entries written
// since the window was last emptied.

module temperature_window_statistics
  import tws_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  command_i,
  input  logic [SAMPLE_W-1:0]   sample_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [TEMP_W-1:0]     current_temp_o,
  output logic [TEMP_W-1:0]     mean_temp_o,
  output logic [TEMP_W-1:0]     max_temp_o,
  output logic [TEMP_W-1:0]     min_temp_o,
  output logic [SAMPLE_W-1:0]   block_average_o,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e               state_q;
  logic [SCALE_W-1:0]   scale_q;
  logic [WLEN_W-1:0]    wlen_q;
  logic [ACC_W-1:0]     acc_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [SAMPLE_W-1:0]  avg_q;
  logic [TEMP_W-1:0]    cur_q;
  logic [WIN_IDX_W-1:0] wp_q;
  logic [WIN_IDX_W-1:0] pos_q;
  logic [LEN_W-1:0]     fill_q;
  logic [SUM_W-1:0]     sum_q;
  logic [TEMP_W-1:0]    hi_q;
  logic [TEMP_W-1:0]    lo_q;
  logic [TEMP_W-1:0]    mean_q;
  logic                 out_valid_q;
  logic [TEMP_W-1:0]    out_cur_q, out_mean_q, out_max_q, out_min_q;
  logic [SAMPLE_W-1:0]  out_avg_q;

  logic [TEMP_W-1:0]    win_mem [WINDOW_DEPTH];
  logic [TEMP_W-1:0]    rd_data_q;

  logic                 in_xfer, cfg_xfer, out_xfer, out_free;
  logic [ACC_W-1:0]     acc_sum;
  logic [PROD_W-1:0]    prod;
  logic [LEN_W-1:0]     len;
  logic [WIN_IDX_W-1:0] pos;
  logic [LEN_W-1:0]     pos_inc;
  logic                 fill_grow;
  logic [LEN_W-1:0]     fill_d;
  logic [SUM_W-1:0]     sum_d;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  // handshakes
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;

  // block accumulation and scaling
  assign acc_sum = acc_q + ACC_W'(sample_i);
  assign prod    = PROD_W'(avg_q) * PROD_W'(scale_q);

  // window position and update
  assign len       = effective_len(wlen_q);
  assign pos       = (LEN_W'(wp_q) >= len) ? '0 : wp_q;
  assign pos_inc   = LEN_W'(pos_q) + LEN_W'(1);
  assign fill_grow = fill_q < len;
  assign fill_d    = fill_grow ? fill_q + LEN_W'(1) : fill_q;
  assign sum_d     = fill_grow ? sum_q + SUM_W'(cur_q)
                               : sum_q - SUM_W'(rd_data_q) + SUM_W'(cur_q);

  // mean divider request
  assign div_req.start    = (state_q == ST_UPD);
  assign div_req.dividend = sum_d;
  assign div_req.divisor  = fill_d;

  tws_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // window memory, registered read
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      rd_data_q <= win_mem[pos];
    end
    if (state_q == ST_UPD) begin
      win_mem[pos_q] <= cur_q;
    end
  end

  // sequencer, statistics and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scale_q     <= SCALE_RESET;
      wlen_q      <= WLEN_RESET;
      acc_q       <= '0;
      cnt_q       <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      hi_q        <= '0;
      lo_q        <= LOW_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cfg_xfer) begin
            unique case (cfg_index_i)
              REG_SCALE_FACTOR: begin
                scale_q <= cfg_data_i[SCALE_W-1:0];
              end
              REG_WINDOW_LENGTH: begin
                wlen_q <= cfg_data_i[WLEN_W-1:0];
                wp_q   <= '0;
                fill_q <= '0;
                sum_q  <= '0;
              end
              default: begin
              end
            endcase
          end
          if (in_xfer) begin
            if (command_i == CMD_CLEAR) begin
              acc_q  <= '0;
              cnt_q  <= '0;
              wp_q   <= '0;
              fill_q <= '0;
              sum_q  <= '0;
              hi_q   <= '0;
              lo_q   <= LOW_RESET;
            end else if (cnt_q == CNT_W'(BLOCK_LEN - 1)) begin
              avg_q   <= acc_sum[ACC_W-1 -: SAMPLE_W];
              acc_q   <= '0;
              cnt_q   <= '0;
              state_q <= ST_MUL;
            end else begin
              acc_q <= acc_sum;
              cnt_q <= cnt_q + CNT_W'(1);
            end
          end
        end
        ST_MUL: begin
          cur_q   <= prod[PROD_W-1 -: TEMP_W];
          pos_q   <= pos;
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          fill_q  <= fill_d;
          sum_q   <= sum_d;
          wp_q    <= (pos_inc >= len) ? '0 : pos_inc[WIN_IDX_W-1:0];
          if (cur_q > hi_q) begin
            hi_q <= cur_q;
          end
          if (cur_q < lo_q) begin
            lo_q <= cur_q;
          end
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            mean_q  <= div_rsp.quotient[TEMP_W-1:0];
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && out_free) begin
      out_cur_q  <= cur_q;
      out_mean_q <= mean_q;
      out_max_q  <= hi_q;
      out_min_q  <= lo_q;
      out_avg_q  <= avg_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign current_temp_o  = out_cur_q;
  assign mean_temp_o     = out_mean_q;
  assign max_temp_o      = out_max_q;
  assign min_temp_o      = out_min_q;
  assign block_average_o = out_avg_q;

endmodule
